### design/vdd_pkg.sv
// Shared types and constants for the varint decimal decoder.
// Depends on nothing; every module of the decoder imports it.
package vdd_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned SCALE_W     = 8;
  localparam int unsigned NUM_CHUNKS  = 3;
  localparam int unsigned OUT_DATA_W  = 112;

  localparam logic [1:0] TAG_ZERO = 2'd0;
  localparam logic [1:0] TAG_POS  = 2'd1;
  localparam logic [1:0] TAG_NEG  = 2'd2;
  localparam logic [1:0] TAG_MIN  = 2'd3;

  localparam logic [WORD_W-1:0] CHUNK_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [SCALE_W-1:0] decimal_scale;
    logic               is_negative;
    logic [WORD_W-1:0]  mag_word_high;
    logic [WORD_W-1:0]  mag_word_mid;
    logic [WORD_W-1:0]  mag_word_low;
  } result_t;

endpackage

### design/vdd_in_reg.sv
// Input register stage of the varint decimal decoder.
// Holds one accepted byte until the decode stage takes it. Uses vdd_pkg.
module vdd_in_reg
  import vdd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [BYTE_W-1:0] s_tdata,
  input  logic              take,
  output logic              in_valid,
  output logic [BYTE_W-1:0] in_byte
);

  assign s_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (take) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

endmodule

### design/vdd_decode.sv
// Decode stage of the varint decimal decoder: header tags, varint gathering
// and the chunk walk that settles fixed chunks. Uses vdd_pkg.
module vdd_decode
  import vdd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              out_free,
  output logic              take,
  output logic              res_valid,
  output result_t           res
);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_CHUNK0 = 3'd1;
  localparam logic [2:0] PH_CHUNK1 = 3'd2;
  localparam logic [2:0] PH_CHUNK2 = 3'd3;
  localparam logic [2:0] PH_CHUNK3 = 3'd4;

  localparam logic [5:0] VARINT_BITS = 6'd7;
  localparam logic [5:0] BITPOS_SAT  = 6'd35;
  localparam logic [5:0] BITPOS_LIM  = 6'd32;

  function automatic logic [1:0] tag_at(input logic [BYTE_W-1:0] tags, input logic [1:0] idx);
    logic [1:0] t;
    case (idx)
      2'd0:    t = tags[7:6];
      2'd1:    t = tags[5:4];
      2'd2:    t = tags[3:2];
      default: t = tags[1:0];
    endcase
    return t;
  endfunction

  function automatic logic [2:0] chunk_phase(input logic [1:0] idx);
    logic [2:0] p;
    case (idx)
      2'd0:    p = PH_CHUNK0;
      2'd1:    p = PH_CHUNK1;
      2'd2:    p = PH_CHUNK2;
      default: p = PH_CHUNK3;
    endcase
    return p;
  endfunction

  function automatic logic [WORD_W-1:0] fixed_chunk(input logic [1:0] t);
    return (t == TAG_MIN) ? CHUNK_MIN : '0;
  endfunction

  logic [2:0]        phase, phase_next;
  logic [BYTE_W-1:0] tag_bits, tag_bits_next;
  logic [WORD_W-1:0] accumulator, accumulator_next;
  logic [5:0]        bit_position, bit_position_next;
  logic [WORD_W-1:0] chunk_words [NUM_CHUNKS];

  logic              is_header;
  logic [BYTE_W-1:0] tags;
  logic [WORD_W-1:0] shift_in, acc_or, vint, cur, last_chunk;
  logic [5:0]        bitpos_sum, bitpos_sat;
  logic [1:0]        vint_idx, start_idx, t_first, t_next;
  logic              walk, done, emit;
  logic [WORD_W-1:0] start_val;
  logic [NUM_CHUNKS-1:0] wr_en;
  logic [WORD_W-1:0] wr_val [NUM_CHUNKS];

  always_comb begin
    take       = in_valid && out_free;
    is_header  = (phase == PH_HEADER) || (phase > PH_CHUNK3);
    tags       = is_header ? in_byte : tag_bits;
    shift_in   = {25'd0, in_byte[6:0]} << bit_position[4:0];
    acc_or     = (bit_position < BITPOS_LIM) ? (accumulator | shift_in) : accumulator;
    bitpos_sum = bit_position + VARINT_BITS;
    bitpos_sat = (bitpos_sum > BITPOS_SAT) ? BITPOS_SAT : bitpos_sum;
    case (phase)
      PH_CHUNK0: vint_idx = 2'd0;
      PH_CHUNK1: vint_idx = 2'd1;
      PH_CHUNK2: vint_idx = 2'd2;
      default:   vint_idx = 2'd3;
    endcase
    vint    = (tag_at(tags, vint_idx) == TAG_NEG) ? (32'd0 - acc_or) : acc_or;
    t_first = tag_at(in_byte, 2'd0);

    phase_next        = phase;
    tag_bits_next     = tag_bits;
    accumulator_next  = '0;
    bit_position_next = '0;
    walk              = 1'b0;
    start_idx         = 2'd0;
    start_val         = '0;

    if (is_header) begin
      tag_bits_next = in_byte;
      if (t_first == TAG_POS || t_first == TAG_NEG) begin
        phase_next = PH_CHUNK0;
      end else begin
        walk      = 1'b1;
        start_val = fixed_chunk(t_first);
      end
    end else if (in_byte[7]) begin
      accumulator_next  = acc_or;
      bit_position_next = bitpos_sat;
    end else begin
      walk      = 1'b1;
      start_idx = vint_idx;
      start_val = vint;
    end

    done       = 1'b0;
    emit       = 1'b0;
    cur        = start_val;
    last_chunk = '0;
    wr_en      = '0;
    t_next     = TAG_ZERO;
    for (int j = 0; j < NUM_CHUNKS; j++) begin
      wr_val[j] = '0;
    end
    if (walk) begin
      phase_next = PH_HEADER;
      for (int j = 0; j <= NUM_CHUNKS; j++) begin
        if (!done && (j >= int'(start_idx))) begin
          if (j == NUM_CHUNKS) begin
            emit       = 1'b1;
            last_chunk = cur;
            done       = 1'b1;
          end else begin
            wr_en[j]  = 1'b1;
            wr_val[j] = cur;
            t_next    = tag_at(tags, 2'(j + 1));
            if (t_next == TAG_POS || t_next == TAG_NEG) begin
              phase_next = chunk_phase(2'(j + 1));
              done       = 1'b1;
            end else begin
              cur = fixed_chunk(t_next);
            end
          end
        end
      end
    end

    res_valid         = take && emit;
    res.mag_word_low  = wr_en[0] ? wr_val[0] : chunk_words[0];
    res.mag_word_mid  = wr_en[1] ? wr_val[1] : chunk_words[1];
    res.mag_word_high = wr_en[2] ? wr_val[2] : chunk_words[2];
    res.is_negative   = last_chunk[31];
    res.decimal_scale = last_chunk[23:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      tag_bits     <= '0;
      accumulator  <= '0;
      bit_position <= '0;
    end else if (take) begin
      phase        <= phase_next;
      tag_bits     <= tag_bits_next;
      accumulator  <= accumulator_next;
      bit_position <= bit_position_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_CHUNKS; k++) begin
      if (take && wr_en[k]) begin
        chunk_words[k] <= wr_val[k];
      end
    end
  end

endmodule

### design/vdd_out_reg.sv
// Result register of the varint decimal decoder.
// Holds one finished result until the downstream side takes it. Uses vdd_pkg.
module vdd_out_reg
  import vdd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    res_valid,
  input  result_t res,
  input  logic    m_tready,
  output logic    m_tvalid,
  output result_t out_res,
  output logic    out_free
);

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      out_res <= res;
    end
  end

endmodule

### design/varint_decimal_decoder.sv
// Top level of the varint decimal decoder: input register, decode stage and
// result register. Depends on vdd_pkg, vdd_in_reg, vdd_decode and vdd_out_reg.
//
//   Channel  Direction  Word
//   s_*      in         tdata[7:0] data_byte
//   m_*      out        tdata[111:0] magnitude, sign and scale
//
// One byte per cycle is sustained while the result register is not stalled.
// An accepted byte passes the input register and then the result register on its way to the master side.
// A header whose tags need no bytes yields its result from that header alone.
// Reset is synchronous and clears all control state; the chunk store is not reset.
// While the result register is stalled, one further byte is held in the input register.
module varint_decimal_decoder
  import vdd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] data_byte
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // [31:0] mag_word_low, [63:32] mag_word_mid,
                                           // [95:64] mag_word_high, [96] is_negative,
                                           // [104:97] decimal_scale, [111:105] zero
);

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              take;
  logic              out_free;
  logic              res_valid;
  result_t           res;
  result_t           out_res;

  vdd_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .take     (take),
    .in_valid (in_valid),
    .in_byte  (in_byte)
  );

  vdd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_byte   (in_byte),
    .out_free  (out_free),
    .take      (take),
    .res_valid (res_valid),
    .res       (res)
  );

  vdd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .out_res   (out_res),
    .out_free  (out_free)
  );

  assign m_tdata = {7'd0, out_res.decimal_scale, out_res.is_negative,
                    out_res.mag_word_high, out_res.mag_word_mid, out_res.mag_word_low};

  a_take_needs_room: assert property (@(posedge clk) disable iff (rst)
    take |-> (in_valid && (!m_tvalid || m_tready)))
    else $error("decode stage consumed a word while the result register was blocked");

  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    (in_valid && (!m_tvalid || m_tready)) |-> take)
    else $error("decode stage left a word waiting with room downstream");

  a_ready_only_when_free: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && m_tvalid && !m_tready))
    else $error("input side stalled without a blocked result");

  a_result_from_decode: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(res_valid))
    else $error("result appeared without a decoded number");

endmodule
